// File: sv/ira_pkg.sv
// ---------------------------------------------------------------------------
// ira_pkg
// shared types, constants and helpers of the integer radix ascii formatter
// ---------------------------------------------------------------------------
`default_nettype none

package ira_pkg;

    localparam int MAX_WIDTH = 30;
    localparam int DIGIT_BUF = 12;
    localparam int PAD_W     = $clog2(MAX_WIDTH + 1);
    localparam int DIG_W     = $clog2(DIGIT_BUF + 1);
    localparam int IDX_W     = $clog2(DIGIT_BUF);

    // reciprocal of ten, used with a 35-bit right shift
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LOWA  = 8'h61;

    typedef enum logic [1:0] {
        OP_SDEC = 2'd0,
        OP_UDEC = 2'd1,
        OP_OCT  = 2'd2,
        OP_HEX  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_PAD,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic emit_sign;
        logic emit_pad;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic negative;
        logic pad_zero;
        logic pad_one;
        logic dig_one;
        logic out_free;
    } status_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            c = CHAR_LOWA + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

    function automatic logic [PAD_W-1:0] sat_width(input logic [4:0] w);
        logic [PAD_W-1:0] r;
        if (int'(w) > MAX_WIDTH)
        begin
            r = PAD_W'(MAX_WIDTH);
        end
        else
        begin
            r = PAD_W'(w);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/ira_ctrl.sv
// ---------------------------------------------------------------------------
// ira_ctrl
// sequencer: accept, convert digit by digit, then emit sign, pads and digits
// ---------------------------------------------------------------------------
`default_nettype none

module ira_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire ira_pkg::status_t sts,
    output ira_pkg::cmd_t        cmd
);

    ira_pkg::state_t state_reg;
    ira_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ira_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ira_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ira_pkg::ST_CONV;
                end
            end
            ira_pkg::ST_CONV:
            begin
                if (sts.conv_done)
                begin
                    state_next = ira_pkg::ST_SIGN;
                end
            end
            ira_pkg::ST_SIGN:
            begin
                if (!sts.negative || sts.out_free)
                begin
                    state_next = sts.pad_zero ? ira_pkg::ST_DIGIT : ira_pkg::ST_PAD;
                end
            end
            ira_pkg::ST_PAD:
            begin
                if (sts.out_free && sts.pad_one)
                begin
                    state_next = ira_pkg::ST_DIGIT;
                end
            end
            ira_pkg::ST_DIGIT:
            begin
                if (sts.out_free && sts.dig_one)
                begin
                    state_next = ira_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ira_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ira_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ira_pkg::ST_CONV:
            begin
                cmd.conv = 1'b1;
            end
            ira_pkg::ST_SIGN:
            begin
                cmd.emit_sign = sts.negative && sts.out_free;
            end
            ira_pkg::ST_PAD:
            begin
                cmd.emit_pad = sts.out_free;
            end
            ira_pkg::ST_DIGIT:
            begin
                cmd.emit_digit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/ira_dp.sv
// ---------------------------------------------------------------------------
// ira_dp
// datapath: magnitude, digit extraction, digit buffer and output register
// ---------------------------------------------------------------------------
`default_nettype none

module ira_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [39:0]      s_tdata,   // value[31:0], zero_pad, min_width[4:0]
    input  wire logic [1:0]       s_tuser,   // opcode[1:0]
    input  wire ira_pkg::cmd_t    cmd,
    output ira_pkg::status_t      sts,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,   // char_code[7:0]
    output logic                  m_tlast    // last_char
);

    logic [31:0]               mag_reg, mag_next;
    ira_pkg::opcode_t          mode_reg, mode_next;
    logic                      zpad_reg, zpad_next;
    logic                      neg_reg, neg_next;
    logic [ira_pkg::PAD_W-1:0] pad_reg, pad_next;
    logic [ira_pkg::DIG_W-1:0] ndig_reg, ndig_next;
    logic [3:0]                dbuf_reg [ira_pkg::DIGIT_BUF];
    logic                      out_valid_reg, out_valid_next;
    logic [7:0]                out_char_reg, out_char_next;
    logic                      out_last_reg, out_last_next;

    ira_pkg::opcode_t          in_op;
    logic                      in_neg;
    logic [63:0]               prod;
    logic [31:0]               quot;
    logic [3:0]                digit;
    logic [ira_pkg::IDX_W-1:0] wr_idx;
    logic [ira_pkg::IDX_W-1:0] rd_idx;
    logic [ira_pkg::DIG_W-1:0] rd_cnt;
    logic                      out_free;

    assign in_op  = ira_pkg::opcode_t'(s_tuser[1:0]);
    assign in_neg = (in_op == ira_pkg::OP_SDEC) && s_tdata[31];

    // divide by ten through the reciprocal; remainder needs only the low bits
    assign prod = 64'(mag_reg) * 64'(ira_pkg::RECIP_TEN);

    always_comb
    begin
        case (mode_reg)
            ira_pkg::OP_HEX:
            begin
                quot  = {4'd0, mag_reg[31:4]};
                digit = mag_reg[3:0];
            end
            ira_pkg::OP_OCT:
            begin
                quot  = {3'd0, mag_reg[31:3]};
                digit = {1'b0, mag_reg[2:0]};
            end
            default:
            begin
                quot  = 32'(prod[63:ira_pkg::RECIP_SHIFT]);
                digit = mag_reg[3:0] - {quot[0], 3'd0} - {quot[2:0], 1'b0};
            end
        endcase
    end

    assign wr_idx   = ndig_reg[ira_pkg::IDX_W-1:0];
    assign rd_cnt   = ndig_reg - ira_pkg::DIG_W'(1);
    assign rd_idx   = rd_cnt[ira_pkg::IDX_W-1:0];
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        mag_next       = mag_reg;
        mode_next      = mode_reg;
        zpad_next      = zpad_reg;
        neg_next       = neg_reg;
        pad_next       = pad_reg;
        ndig_next      = ndig_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cmd.load)
        begin
            mode_next = in_op;
            zpad_next = s_tdata[32];
            neg_next  = in_neg;
            mag_next  = in_neg ? (32'd0 - s_tdata[31:0]) : s_tdata[31:0];
            pad_next  = ira_pkg::sat_width(s_tdata[37:33]);
            ndig_next = '0;
        end
        if (cmd.conv)
        begin
            mag_next  = quot;
            ndig_next = ndig_reg + ira_pkg::DIG_W'(1);
            // every digit uses up one place of the minimum width
            if (pad_reg != '0)
            begin
                pad_next = pad_reg - ira_pkg::PAD_W'(1);
            end
        end
        if (cmd.emit_sign)
        begin
            out_valid_next = 1'b1;
            out_char_next  = ira_pkg::CHAR_MINUS;
            out_last_next  = 1'b0;
        end
        if (cmd.emit_pad)
        begin
            out_valid_next = 1'b1;
            out_char_next  = zpad_reg ? ira_pkg::CHAR_ZERO : ira_pkg::CHAR_SPACE;
            out_last_next  = 1'b0;
            pad_next       = pad_reg - ira_pkg::PAD_W'(1);
        end
        if (cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = ira_pkg::digit_char(dbuf_reg[rd_idx]);
            out_last_next  = (ndig_reg == ira_pkg::DIG_W'(1));
            ndig_next      = rd_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        mode_reg     <= mode_next;
        zpad_reg     <= zpad_next;
        neg_reg      <= neg_next;
        pad_reg      <= pad_next;
        ndig_reg     <= ndig_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (cmd.conv)
        begin
            dbuf_reg[wr_idx] <= digit;
        end
    end

    assign sts.conv_done = (quot == 32'd0);
    assign sts.negative  = neg_reg;
    assign sts.pad_zero  = (pad_reg == '0);
    assign sts.pad_one   = (pad_reg == ira_pkg::PAD_W'(1));
    assign sts.dig_one   = (ndig_reg == ira_pkg::DIG_W'(1));
    assign sts.out_free  = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // a new character only goes into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_pad || cmd.emit_digit) |-> out_free)
        else $error("character emitted over a pending transaction");

    // conversion never runs past the digit buffer
    a_conv_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.conv |-> (int'(ndig_reg) < ira_pkg::DIGIT_BUF))
        else $error("digit buffer overflow");

    // the final digit carries tlast
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit && ndig_reg == ira_pkg::DIG_W'(1)) |=> (m_tvalid && m_tlast))
        else $error("last digit without tlast");

    // digits are never emitted from an empty buffer
    a_dig_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> (ndig_reg != '0))
        else $error("digit emitted from empty buffer");

endmodule

`default_nettype wire

// File: sv/integer_radix_ascii_formatter.sv
// ---------------------------------------------------------------------------
// integer_radix_ascii_formatter
// formats a 32-bit number as ascii text in decimal, octal or lower-case hex
// ---------------------------------------------------------------------------
// One number is taken per transaction on the slave side and its text comes
// out one character per transaction on the master side, most significant
// first, with tlast on the final character: a '-' for a negative value in
// signed decimal mode, then '0' or space pads until the digit count reaches
// min_width (saturated at 30), then the digits. A number is accepted, then
// converted in a loop of one digit per step (up to 10 decimal,
// 11 octal or 8 hex digits, one division step of the shared divide-by-radix
// unit each); then the sign is decided, which also writes the '-' when
// there is one, and each further character is written to the output
// register (1 to 31 characters in all), waiting while that register is full.
// The next number is accepted while the final character still waits in
// the output register.
`default_nettype none

module integer_radix_ascii_formatter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // value[31:0], zero_pad, min_width[4:0], zero fill
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // char_code[7:0]
    output logic             m_tlast    // last_char
);

    ira_pkg::cmd_t    cmd;
    ira_pkg::status_t sts;

    ira_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ira_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: bench/integer_radix_ascii_formatter_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// integer_radix_ascii_formatter_tb
// self-checking bench for the integer radix ascii formatter
// ---------------------------------------------------------------------------
// Numbers go in on the slave stream. A behavioral formatter in the bench
// builds the expected text of each accepted number, and every character
// that leaves the master stream is checked against it, tlast included.
// The directed tests cover zero, the all-ones and most negative values and
// the width rules. A hold-off test and a long random mix follow, with
// random gaps on both streams.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_radix_ascii_formatter_tb;

    localparam int         CYCLE_LIMIT = 800000;
    localparam int         SAT_WIDTH   = 30;
    localparam int         MAX_GAP     = 19;
    localparam int         SETTLE      = 60;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_LOWA  = 8'h61;

    typedef struct packed {
        logic [7:0] code;
        logic       is_last;
    } text_char_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // value[31:0], zero_pad, min_width[4:0], zero fill
    logic [1:0]  s_tuser  = '0;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // char_code[7:0]
    logic        m_tlast;         // last_char

    text_char_t  text_due[$];
    int          errors        = 0;
    int          numbers_sent  = 0;
    int          chars_checked = 0;
    int          mode_count[4] = '{default: 0};
    int          cycles        = 0;
    int          rx_hold_req   = 0;
    bit          tx_idle       = 1'b1;
    bit          rx_idle       = 1'b1;

    integer_radix_ascii_formatter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters still due", cycles,
                     text_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        errors++;
        if (errors <= 30)
        begin
            $display("mismatch at %0t: %s: expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // expected text of one number: sign, pads, then digits most significant first
    function automatic void predict_text(input logic [31:0] value,
                                         input ira_pkg::opcode_t op,
                                         input logic zpad, input logic [4:0] width);
        logic [7:0]  digit_q[$];
        logic [31:0] mag;
        logic [31:0] radix;
        logic [31:0] rem;
        bit          neg;
        int          span;
        radix = (op == ira_pkg::OP_OCT) ? 32'd8 : (op == ira_pkg::OP_HEX) ? 32'd16 : 32'd10;
        neg   = (op == ira_pkg::OP_SDEC) && value[31];
        mag   = neg ? 32'd0 - value : value;
        span  = (int'(width) > SAT_WIDTH) ? SAT_WIDTH : int'(width);
        do
        begin
            rem = mag % radix;
            digit_q.push_front((rem < 32'd10) ? ASCII_ZERO + rem[7:0]
                                              : ASCII_LOWA + rem[7:0] - 8'd10);
            mag = mag / radix;
        end
        while (mag != 32'd0);
        if (neg)
        begin
            text_due.push_back('{ASCII_MINUS, 1'b0});
        end
        for (int i = digit_q.size(); i < span; i++)
        begin
            text_due.push_back('{zpad ? ASCII_ZERO : ASCII_SPACE, 1'b0});
        end
        foreach (digit_q[i])
        begin
            text_due.push_back('{digit_q[i], i == digit_q.size() - 1});
        end
    endfunction

    // valid stays high after a transaction so back-to-back items need no toggle
    task automatic send_number(input logic [31:0] value, input ira_pkg::opcode_t op,
                               input logic zpad, input logic [4:0] width);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {2'b00, width, zpad, value};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_text(value, op, zpad, width);
        numbers_sent++;
        mode_count[op]++;
    endtask

    task automatic wait_text_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (text_due.size() != 0);
    endtask

    initial
    begin : rx_side
        int gap_left;
        int hold_left;
        gap_left  = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (m_tvalid && m_tready)
            begin
                gap_left = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= rst_n;
            end
        end
    end

    always @(posedge clk)
    begin : char_check
        text_char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (text_due.size() == 0)
            begin
                report_mismatch("character with nothing due", 0, m_tdata);
            end
            else
            begin
                want = text_due.pop_front();
                if (m_tdata !== want.code)
                begin
                    report_mismatch("char_code", want.code, m_tdata);
                end
                if (m_tlast !== want.is_last)
                begin
                    report_mismatch("last_char", want.is_last, m_tlast);
                end
                chars_checked++;
            end
        end
    end

    task automatic test_zero_value();
        send_number(32'd0, ira_pkg::OP_SDEC, 1'b0, 5'd0);
        send_number(32'd0, ira_pkg::OP_UDEC, 1'b1, 5'd0);
        send_number(32'd0, ira_pkg::OP_OCT,  1'b0, 5'd1);
        send_number(32'd0, ira_pkg::OP_HEX,  1'b1, 5'd0);
        send_number(32'd0, ira_pkg::OP_SDEC, 1'b0, 5'd5);
        wait_text_drained();
    endtask

    task automatic test_extremes();
        send_number(32'hFFFF_FFFF, ira_pkg::OP_SDEC, 1'b0, 5'd0);
        send_number(32'hFFFF_FFFF, ira_pkg::OP_UDEC, 1'b0, 5'd0);
        send_number(32'hFFFF_FFFF, ira_pkg::OP_OCT,  1'b0, 5'd0);
        send_number(32'hFFFF_FFFF, ira_pkg::OP_HEX,  1'b0, 5'd0);
        // most negative value keeps its full magnitude
        send_number(32'h8000_0000, ira_pkg::OP_SDEC, 1'b0, 5'd0);
        send_number(32'h8000_0000, ira_pkg::OP_UDEC, 1'b1, 5'd3);
        send_number(32'h7FFF_FFFF, ira_pkg::OP_SDEC, 1'b1, 5'd0);
        send_number(32'h7FFF_FFFF, ira_pkg::OP_HEX,  1'b1, 5'd8);
        wait_text_drained();
    endtask

    task automatic test_width_rules();
        // width 31 saturates, so 31 characters with the sign
        send_number(32'hFFFF_FFD6, ira_pkg::OP_SDEC, 1'b1, 5'd31);
        send_number(32'hDEAD_BEEF, ira_pkg::OP_HEX,  1'b0, 5'd30);
        send_number(32'd12345,     ira_pkg::OP_UDEC, 1'b1, 5'd5);
        send_number(32'd8,         ira_pkg::OP_OCT,  1'b1, 5'd1);
        send_number(32'hABCD_EF01, ira_pkg::OP_HEX,  1'b1, 5'd16);
        send_number(32'hFFFF_FFFF, ira_pkg::OP_OCT,  1'b0, 5'd11);
        send_number(32'd7,         ira_pkg::OP_UDEC, 1'b0, 5'd30);
        wait_text_drained();
    endtask

    // receiver stalls long while numbers keep coming, so the input must back up
    task automatic test_output_holdoff();
        tx_idle     = 1'b0;
        rx_hold_req = 400;
        for (int i = 0; i < 8; i++)
        begin
            send_number($urandom, ira_pkg::opcode_t'($urandom_range(0, 3)), 1'($urandom),
                        5'($urandom_range(0, 31)));
        end
        wait_text_drained();
        tx_idle = 1'b1;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, 15);
            1:       v = $urandom_range(0, 99999);
            2:       v = $urandom | 32'h8000_0000;
            3:       v = 32'd0 - $urandom_range(1, 1000);
            4:       v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_random_numbers(input int count);
        logic [4:0] width;
        for (int i = 0; i < count; i++)
        begin
            width = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, 12));
            send_number(pick_value(), ira_pkg::opcode_t'($urandom_range(0, 3)),
                        1'($urandom), width);
        end
    endtask

    task automatic test_random_mix();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_random_numbers(60);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_random_numbers(30);
        tx_idle = 1'b1;
        send_random_numbers(25);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        send_random_numbers(25);
        wait_text_drained();
    endtask

    initial
    begin : run
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_value();
        test_extremes();
        test_width_rules();
        test_output_holdoff();
        test_random_mix();
        repeat (SETTLE) @(posedge clk);
        $display("run: %0d numbers (signed %0d, unsigned %0d, octal %0d, hex %0d), %0d chars",
                 numbers_sent, mode_count[ira_pkg::OP_SDEC], mode_count[ira_pkg::OP_UDEC],
                 mode_count[ira_pkg::OP_OCT], mode_count[ira_pkg::OP_HEX], chars_checked);
        $display("run: zero, extreme values, width saturation, output hold-off, random gaps");
        if (errors == 0 && text_due.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d mismatches, %0d characters never arrived", errors, text_due.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
sv/ira_pkg.sv
sv/ira_ctrl.sv
sv/ira_dp.sv
sv/integer_radix_ascii_formatter.sv
bench/integer_radix_ascii_formatter_tb.sv
